FILE: design/dro_pkg.sv
// constants, types and lookup functions for the dead-reckoning odometry block
package dro_pkg;

    // field widths
    localparam int W_CNT   = 16;   // sensor counts
    localparam int W_YAW   = 17;   // gyro yaw, hundredths of a degree
    localparam int W_POS   = 48;   // q32.16 position
    localparam int W_HEAD  = 12;   // heading, tenths of a degree
    localparam int W_CFG   = 13;   // heading registers
    localparam int W_SUM   = 16;   // heading before reduction
    localparam int W_RES   = 13;   // residual angle inside a quarter turn
    localparam int W_VEC   = 42;   // cordic vector components
    localparam int W_ANG   = 25;   // cordic angle accumulator
    localparam int W_MULA  = 22;   // multiplier operand a (signed)
    localparam int W_MULB  = 24;   // multiplier operand b (signed)
    localparam int W_PROD  = W_MULA + W_MULB;
    localparam int W_ACC   = 66;   // scaling accumulator
    localparam int W_STEP  = 28;   // scaled step, q12.16 mm
    localparam int W_HALF  = 21;   // split point of a vector component
    localparam int W_ITER  = 5;
    localparam int W_TDATA_IN  = 152;
    localparam int W_TDATA_OUT = 112;

    localparam int CORDIC_STEPS = 20;
    localparam int STEP_SHIFT   = 38;
    localparam int DIV10_SHIFT  = 19;

    localparam logic [W_MULB-2:0] STEP_SCALE  = 23'd4071230;  // 2^38 / (41000 * gain)
    localparam logic [W_MULB-2:0] DIV10_RECIP = 23'd52429;    // 2^19 / 10, rounded up

    localparam logic [W_YAW-1:0]        YAW_ROUND  = 17'd5;
    localparam logic signed [W_SUM-1:0] FULL_TURN  = 16'sd3600;
    localparam logic signed [W_RES-1:0] QUARTER    = 13'sd900;
    localparam logic signed [W_RES-1:0] HALF_QUART = 13'sd450;

    localparam logic signed [W_POS-1:0] POS_MAX = {1'b0, {(W_POS-1){1'b1}}};
    localparam logic signed [W_POS-1:0] POS_MIN = {1'b1, {(W_POS-1){1'b0}}};

    // configuration register indexes
    typedef enum logic {
        CFG_START_HEADING = 1'b0,
        CFG_HEADING_CORR  = 1'b1
    } t_cfg_idx;

    // arctangent of 2^-i in units of 1/40960 degree
    function automatic logic signed [W_ANG-1:0] atan_units(input logic [W_ITER-1:0] idx);
        logic signed [W_ANG-1:0] v;
        case (idx)
            5'd0:    v = 25'sd1843200;
            5'd1:    v = 25'sd1088104;
            5'd2:    v = 25'sd574925;
            5'd3:    v = 25'sd291841;
            5'd4:    v = 25'sd146487;
            5'd5:    v = 25'sd73315;
            5'd6:    v = 25'sd36666;
            5'd7:    v = 25'sd18334;
            5'd8:    v = 25'sd9167;
            5'd9:    v = 25'sd4584;
            5'd10:   v = 25'sd2292;
            5'd11:   v = 25'sd1146;
            5'd12:   v = 25'sd573;
            5'd13:   v = 25'sd286;
            5'd14:   v = 25'sd143;
            5'd15:   v = 25'sd72;
            5'd16:   v = 25'sd36;
            5'd17:   v = 25'sd18;
            5'd18:   v = 25'sd9;
            5'd19:   v = 25'sd4;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/dead_reckoning_odometry.sv
// dead-reckoning odometry: sensor step scaling, gyro heading, cordic rotation, position sum
//
//  channel   dir  fields (lowest bit first)
//  s_axis    in   tdata: sensor_x_counts, sensor_y_counts, yaw_centideg, new_x, new_y
//                 tuser: command (1 set position, 0 sensor sample)
//  m_axis    out  tdata: pos_x, pos_y, heading_decideg   tuser: saturated
//  i_cfg_*   in   write enable, register index, 13 bit write data
//
//  a sample request goes from acceptance to result valid through the yaw scaling, the
//  modulo 3600 reduction, the quarter-turn split, twenty cordic iterations on the add/shift
//  unit, the scaling on the shared multiplier and the saturating add. a set-position
//  request gives its result in the next cycle.
//  s_axis_tready is high only while idle; a pending result holds until m_axis_tready.
//  synchronous active-low reset clears position, heading and both heading registers.
module dead_reckoning_odometry
    import dro_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write port
    input  logic                    i_cfg_wr_en,
    input  logic                    i_cfg_addr,
    input  logic [W_CFG-1:0]        i_cfg_wdata,
    // request stream
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [W_TDATA_IN-1:0]   s_axis_tdata,   // x counts, y counts, yaw, new_x, new_y
    input  logic                    s_axis_tuser,   // command
    // result stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [W_TDATA_OUT-1:0]  m_axis_tdata,   // pos_x, pos_y, heading_decideg
    output logic                    m_axis_tuser    // saturated
);

    typedef enum logic [3:0] {
        S_IDLE,   // waiting for a request
        S_YAWM,   // multiply rounded yaw by the reciprocal of ten
        S_YAWS,   // form the unreduced heading
        S_MOD,    // reduce heading into 0..3599
        S_QUAD,   // strip quarter turns, rotate vector by 90 degrees each
        S_CORD,   // cordic iterations
        S_MXL,    // scale x, low half
        S_MXH,    // scale x, high half
        S_MYL,    // finish x, scale y low half
        S_MYH,    // scale y, high half
        S_MEND,   // finish y
        S_ADD,    // saturating position update
        S_OUT     // result waiting
    } t_state;

    t_state r_state;

    // architectural state and configuration
    logic signed [W_POS-1:0]  r_pos_x, r_pos_y;
    logic [W_HEAD-1:0]        r_heading;
    logic                     r_sat;
    logic signed [W_CFG-1:0]  r_start_heading, r_heading_corr;

    // working registers
    logic [W_YAW-1:0]         r_yaw_a;
    logic                     r_yaw_neg;
    logic signed [W_SUM-1:0]  r_h;
    logic signed [W_RES-1:0]  r_r;
    logic signed [W_VEC-1:0]  r_x, r_y;
    logic signed [W_ANG-1:0]  r_z;
    logic [W_ITER-1:0]        r_iter;
    logic signed [W_PROD-1:0] r_prod;
    logic signed [W_ACC-1:0]  r_acc;
    logic signed [W_STEP-1:0] r_step_x, r_step_y;

    // request unpacking
    logic                      w_cmd;
    logic [W_CNT-1:0]          w_sx, w_sy;
    logic [W_YAW-1:0]          w_yaw;
    logic [W_POS-1:0]          w_new_x, w_new_y;

    assign w_cmd   = s_axis_tuser;
    assign w_sx    = s_axis_tdata[15:0];
    assign w_sy    = s_axis_tdata[31:16];
    assign w_yaw   = s_axis_tdata[48:32];
    assign w_new_x = s_axis_tdata[96:49];
    assign w_new_y = s_axis_tdata[144:97];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {4'b0, r_heading, r_pos_y, r_pos_x};
    assign m_axis_tuser  = r_sat;

    logic w_in_take, w_out_take;
    assign w_in_take  = s_axis_tvalid && s_axis_tready;
    assign w_out_take = m_axis_tvalid && m_axis_tready;

    // step vector: x from -y counts, y from -x counts, times 127 * 2^16
    logic signed [W_CNT:0]    w_neg_sx, w_neg_sy;
    logic signed [23:0]       w_cx, w_cy;
    assign w_neg_sy = 17'sd0 - $signed({w_sy[W_CNT-1], w_sy});
    assign w_neg_sx = 17'sd0 - $signed({w_sx[W_CNT-1], w_sx});
    assign w_cx = $signed({w_neg_sy, 7'b0}) - $signed({{7{w_neg_sy[W_CNT]}}, w_neg_sy});
    assign w_cy = $signed({w_neg_sx, 7'b0}) - $signed({{7{w_neg_sx[W_CNT]}}, w_neg_sx});

    // yaw magnitude plus half a tenth, sign kept apart
    logic [W_YAW-1:0] w_yaw_abs;
    assign w_yaw_abs = w_yaw[W_YAW-1] ? (17'd0 - w_yaw) : w_yaw;

    // unreduced heading
    logic [13:0]             w_tenths;
    logic signed [W_SUM-1:0] w_t, w_s;
    assign w_tenths = r_prod[DIV10_SHIFT+13:DIV10_SHIFT];
    assign w_t = r_yaw_neg ? (16'sd0 - $signed({2'b0, w_tenths})) : $signed({2'b0, w_tenths});
    assign w_s = w_t - $signed({{3{r_start_heading[W_CFG-1]}}, r_start_heading})
                     + $signed({{3{r_heading_corr[W_CFG-1]}}, r_heading_corr});

    // shared multiplier
    logic signed [W_MULA-1:0] w_mul_a;
    logic signed [W_MULB-1:0] w_mul_b;
    logic signed [W_PROD-1:0] w_prod;

    always_comb begin
        w_mul_b = $signed({1'b0, STEP_SCALE});
        case (r_state)
            S_YAWM: begin
                w_mul_a = $signed({5'b0, r_yaw_a});
                w_mul_b = $signed({1'b0, DIV10_RECIP});
            end
            S_MXL:   w_mul_a = $signed({1'b0, r_x[W_HALF-1:0]});
            S_MXH:   w_mul_a = $signed({r_x[W_VEC-1], r_x[W_VEC-1:W_HALF]});
            S_MYL:   w_mul_a = $signed({1'b0, r_y[W_HALF-1:0]});
            S_MYH:   w_mul_a = $signed({r_y[W_VEC-1], r_y[W_VEC-1:W_HALF]});
            default: w_mul_a = '0;
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // scaling accumulation: low half plus rounding, then high half shifted in
    localparam logic signed [W_ACC-1:0] ROUND_HALF = W_ACC'(1) <<< (STEP_SHIFT - 1);
    logic signed [W_ACC-1:0] w_prod_ext, w_acc_sum;
    assign w_prod_ext = $signed({{(W_ACC-W_PROD){r_prod[W_PROD-1]}}, r_prod});
    assign w_acc_sum  = r_acc + (w_prod_ext <<< W_HALF);

    // cordic micro-rotation, shifts floor
    logic signed [W_VEC-1:0] w_dx, w_dy;
    logic                    w_z_pos;
    assign w_dx    = r_y >>> r_iter;
    assign w_dy    = r_x >>> r_iter;
    assign w_z_pos = !r_z[W_ANG-1];

    // saturating position update
    logic signed [W_POS:0] w_sum_x, w_sum_y;
    logic                  w_ovf_x, w_ovf_y;
    assign w_sum_x = $signed({r_pos_x[W_POS-1], r_pos_x})
                   + $signed({{(W_POS+1-W_STEP){r_step_x[W_STEP-1]}}, r_step_x});
    assign w_sum_y = $signed({r_pos_y[W_POS-1], r_pos_y})
                   + $signed({{(W_POS+1-W_STEP){r_step_y[W_STEP-1]}}, r_step_y});
    assign w_ovf_x = w_sum_x[W_POS] != w_sum_x[W_POS-1];
    assign w_ovf_y = w_sum_y[W_POS] != w_sum_y[W_POS-1];

    // sequencer, architectural state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_pos_x         <= '0;
            r_pos_y         <= '0;
            r_heading       <= '0;
            r_sat           <= 1'b0;
            r_start_heading <= '0;
            r_heading_corr  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_START_HEADING: r_start_heading <= $signed(i_cfg_wdata);
                    CFG_HEADING_CORR:  r_heading_corr  <= $signed(i_cfg_wdata);
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_take) begin
                        if (w_cmd) begin
                            // set position: heading untouched, never clipped
                            r_pos_x <= $signed(w_new_x);
                            r_pos_y <= $signed(w_new_y);
                            r_sat   <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_YAWM;
                        end
                    end
                end
                S_YAWM: r_state <= S_YAWS;
                S_YAWS: r_state <= S_MOD;
                S_MOD: begin
                    if (!(r_h < 16'sd0) && (r_h < FULL_TURN)) begin
                        r_heading <= r_h[W_HEAD-1:0];
                        r_state   <= S_QUAD;
                    end
                end
                S_QUAD: begin
                    if (!(r_r > HALF_QUART)) begin
                        r_state <= S_CORD;
                    end
                end
                S_CORD: begin
                    if (r_iter == W_ITER'(CORDIC_STEPS - 1)) begin
                        r_state <= S_MXL;
                    end
                end
                S_MXL:  r_state <= S_MXH;
                S_MXH:  r_state <= S_MYL;
                S_MYL:  r_state <= S_MYH;
                S_MYH:  r_state <= S_MEND;
                S_MEND: r_state <= S_ADD;
                S_ADD: begin
                    r_pos_x <= w_ovf_x ? (w_sum_x[W_POS] ? POS_MIN : POS_MAX)
                                       : w_sum_x[W_POS-1:0];
                    r_pos_y <= w_ovf_y ? (w_sum_y[W_POS] ? POS_MIN : POS_MAX)
                                       : w_sum_y[W_POS-1:0];
                    r_sat   <= w_ovf_x || w_ovf_y;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_yaw_a   <= w_yaw_abs + YAW_ROUND;
                r_yaw_neg <= w_yaw[W_YAW-1];
                r_x       <= $signed({{2{w_cx[23]}}, w_cx, 16'b0});
                r_y       <= $signed({{2{w_cy[23]}}, w_cy, 16'b0});
            end
            S_YAWM: r_prod <= w_prod;
            S_YAWS: r_h    <= w_s;
            S_MOD: begin
                if (r_h < 16'sd0) begin
                    r_h <= r_h + FULL_TURN;
                end else if (!(r_h < FULL_TURN)) begin
                    r_h <= r_h - FULL_TURN;
                end else begin
                    r_r <= r_h[W_RES-1:0];
                end
            end
            S_QUAD: begin
                // each quarter turn stripped rotates the vector by 90 degrees
                if (r_r > HALF_QUART) begin
                    r_r <= r_r - QUARTER;
                    r_x <= -r_y;
                    r_y <= r_x;
                end else begin
                    r_z    <= $signed({r_r, 12'b0});
                    r_iter <= '0;
                end
            end
            S_CORD: begin
                if (w_z_pos) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - atan_units(r_iter);
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + atan_units(r_iter);
                end
                r_iter <= r_iter + W_ITER'(1);
            end
            S_MXL: r_prod <= w_prod;
            S_MXH: begin
                r_prod <= w_prod;
                r_acc  <= w_prod_ext + ROUND_HALF;
            end
            S_MYL: begin
                r_prod   <= w_prod;
                r_step_x <= w_acc_sum[W_ACC-1:STEP_SHIFT];
            end
            S_MYH: begin
                r_prod <= w_prod;
                r_acc  <= w_prod_ext + ROUND_HALF;
            end
            S_MEND: r_step_y <= w_acc_sum[W_ACC-1:STEP_SHIFT];
            default: ;
        endcase
    end

`ifndef SYNTH
    // never accepting a request while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("request accepted while result pending");

    // reduced heading always inside one turn
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heading < W_HEAD'(3600))
        else $error("heading outside 0..3599");

    // set-position request gives its result on the next cycle
    a_set_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_take && w_cmd) |=> m_axis_tvalid)
        else $error("set-position result late");

    // cordic iteration count stays within the angle table
    a_iter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORD) |-> (r_iter < W_ITER'(CORDIC_STEPS)))
        else $error("cordic iteration overrun");

    // once a result is taken the block is ready again
    a_ready_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_take |=> s_axis_tready)
        else $error("not ready after result taken");
`endif

endmodule

FILE: tb/dro_checker.sv
// result checker for the odometry block: tracks position and heading and compares each result
module dro_checker
    import dro_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_addr,
    input  logic [W_CFG-1:0]       i_cfg_wdata,
    input  logic                   i_req_valid,
    input  logic                   i_req_ready,
    input  logic [W_TDATA_IN-1:0]  i_req_data,    // x counts, y counts, yaw, new_x, new_y
    input  logic                   i_req_user,    // command
    input  logic                   i_res_valid,
    input  logic                   i_res_ready,
    input  logic [W_TDATA_OUT-1:0] i_res_data,    // pos_x, pos_y, heading_decideg
    input  logic                   i_res_user,    // saturated
    output int                     o_fail_count,
    output int                     o_result_count,
    output int                     o_pending,
    output int                     o_clip_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [W_POS-1:0]  pos_x;
        logic [W_POS-1:0]  pos_y;
        logic [W_HEAD-1:0] heading;
        logic              saturated;
    } t_pose;

    // arctangent of 2^-i, 1/40960 degree units
    longint arctan_tbl [CORDIC_STEPS] = '{
        1843200, 1088104, 574925, 291841, 146487, 73315, 36666, 18334,
        9167, 4584, 2292, 1146, 573, 286, 143, 72, 36, 18, 9, 4
    };

    longint cur_x, cur_y, start_hd, corr_hd;
    int     cur_head;
    t_pose  pose_queue[$];
    int     fails = 0;
    int     results = 0;
    int     clips = 0;

    task automatic note_mismatch(input string fld, input logic [63:0] got,
                                 input logic [63:0] want);
        fails++;
        $display("%0t: %s mismatch at result %0d: got %h, expected %h",
                 $realtime, fld, results, got, want);
    endtask

    // cordic output times the gain-corrected scale, rounded half up into q32.16 mm
    function automatic longint to_q16(input longint v);
        return (v * longint'(STEP_SCALE) + (64'sd1 <<< (STEP_SHIFT - 1))) >>> STEP_SHIFT;
    endfunction

    function automatic t_pose odometry_update(input logic set_cmd,
                                              input logic [W_TDATA_IN-1:0] d);
        t_pose  res;
        longint xc, yc, yaw, tenths, sum, vx, vy, ang, dx, dy, tmp, nx, ny;
        int     quarter, resid;
        res.saturated = 1'b0;
        if (set_cmd) begin
            cur_x = longint'($signed(d[96:49]));
            cur_y = longint'($signed(d[144:97]));
        end else begin
            xc  = longint'($signed(d[15:0]));
            yc  = longint'($signed(d[31:16]));
            yaw = longint'($signed(d[48:32]));
            // round to tenths, half away from zero
            tenths = (yaw < 0) ? -((-yaw + 5) / 10) : (yaw + 5) / 10;
            sum = (tenths - start_hd + corr_hd) % 3600;
            if (sum < 0)
                sum += 3600;
            cur_head = int'(sum);
            // axes swapped and negated, 127/41000 mm per count scaled by 2^16
            vx = -yc * 127 * 65536;
            vy = -xc * 127 * 65536;
            quarter = cur_head / 900;
            resid   = cur_head % 900;
            if (resid > 450) begin
                resid   -= 900;
                quarter += 1;
            end
            for (int i = 0; i < (quarter & 3); i++) begin
                tmp = vx;
                vx  = -vy;
                vy  = tmp;
            end
            ang = longint'(resid) * 4096;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = vy >>> i;
                dy = vx >>> i;
                if (ang >= 0) begin
                    vx -= dx;
                    vy += dy;
                    ang -= arctan_tbl[i];
                end else begin
                    vx += dx;
                    vy -= dy;
                    ang += arctan_tbl[i];
                end
            end
            nx = cur_x + to_q16(vx);
            ny = cur_y + to_q16(vy);
            if (nx > POS_MAX || nx < POS_MIN || ny > POS_MAX || ny < POS_MIN)
                res.saturated = 1'b1;
            cur_x = (nx > POS_MAX) ? POS_MAX : (nx < POS_MIN) ? POS_MIN : nx;
            cur_y = (ny > POS_MAX) ? POS_MAX : (ny < POS_MIN) ? POS_MIN : ny;
        end
        res.pos_x   = cur_x[W_POS-1:0];
        res.pos_y   = cur_y[W_POS-1:0];
        res.heading = cur_head[W_HEAD-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_pose want;
        if (!i_rst_n) begin
            cur_x    = 0;
            cur_y    = 0;
            cur_head = 0;
            start_hd = 0;
            corr_hd  = 0;
            pose_queue.delete();
        end else begin
            if (i_cfg_wr_en) begin
                if (t_cfg_idx'(i_cfg_addr) == CFG_START_HEADING)
                    start_hd = longint'($signed(i_cfg_wdata));
                else
                    corr_hd = longint'($signed(i_cfg_wdata));
            end
            // results first: one leaving now belongs to an older request
            if (i_res_valid && i_res_ready) begin
                results++;
                if (pose_queue.size() == 0) begin
                    note_mismatch("unexpected result", i_res_data[63:0], '0);
                end else begin
                    want = pose_queue.pop_front();
                    if (i_res_data[47:0] !== want.pos_x)
                        note_mismatch("pos_x", 64'(i_res_data[47:0]), 64'(want.pos_x));
                    if (i_res_data[95:48] !== want.pos_y)
                        note_mismatch("pos_y", 64'(i_res_data[95:48]), 64'(want.pos_y));
                    if (i_res_data[107:96] !== want.heading)
                        note_mismatch("heading", 64'(i_res_data[107:96]), 64'(want.heading));
                    if (i_res_user !== want.saturated)
                        note_mismatch("saturated", 64'(i_res_user), 64'(want.saturated));
                end
            end
            if (i_req_valid && i_req_ready) begin
                want = odometry_update(i_req_user, i_req_data);
                if (want.saturated)
                    clips++;
                pose_queue.push_back(want);
            end
        end
        o_fail_count   <= fails;
        o_result_count <= results;
        o_pending      <= pose_queue.size();
        o_clip_count   <= clips;
    end

endmodule

FILE: tb/dead_reckoning_odometry_tb.sv
// testbench top for the dead-reckoning odometry block: stimulus, handshake pressure, verdict
module dead_reckoning_odometry_tb
    import dro_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REQS_PER_PHASE = 230;   // random requests per heading setting
    localparam int N_PHASES       = 8;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic                   i_cfg_addr    = 1'b0;
    logic [W_CFG-1:0]       i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [W_TDATA_IN-1:0]  s_axis_tdata  = '0;   // x counts, y counts, yaw, new_x, new_y
    logic                   s_axis_tuser  = 1'b0; // command
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [W_TDATA_OUT-1:0] m_axis_tdata;         // pos_x, pos_y, heading_decideg
    logic                   m_axis_tuser;         // saturated

    // no idling on either side once this is set
    logic quiet = 1'b0;

    int fail_count, res_count, pending, clip_count;
    int n_sent    = 0;
    int n_sets    = 0;
    int n_samples = 0;
    int rdy_left  = 0;

    always #5 i_clk = ~i_clk;

    dead_reckoning_odometry dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    dro_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_req_valid    (s_axis_tvalid),
        .i_req_ready    (s_axis_tready),
        .i_req_data     (s_axis_tdata),
        .i_req_user     (s_axis_tuser),
        .i_res_valid    (m_axis_tvalid),
        .i_res_ready    (m_axis_tready),
        .i_res_data     (m_axis_tdata),
        .i_res_user     (m_axis_tuser),
        .o_fail_count   (fail_count),
        .o_result_count (res_count),
        .o_pending      (pending),
        .o_clip_count   (clip_count)
    );

    // result side back-pressure: runs of ready high broken by stalls, both of random length
    always @(posedge i_clk) begin
        if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (rdy_left > 0) begin
            rdy_left <= rdy_left - 1;
        end else if (m_axis_tready) begin
            m_axis_tready <= 1'b0;
            rdy_left      <= $urandom_range(0, 8);
        end else begin
            m_axis_tready <= 1'b1;
            rdy_left      <= $urandom_range(0, 19);
        end
    end

    // one request: optional idle burst, then hold valid until the block takes it;
    // tready only moves on clock edges, so it is looked at on the falling edge
    task automatic send_request(input logic cmd, input logic [15:0] xc,
                                input logic [15:0] yc, input logic [16:0] yaw,
                                input logic [47:0] nx, input logic [47:0] ny);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, ny, nx, yaw, yc, xc};
        s_axis_tuser  <= cmd;
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        n_sent++;
        if (cmd)
            n_sets++;
        else
            n_samples++;
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input int val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val[W_CFG-1:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop sending and let every outstanding result come back, so the block is idle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (res_count != n_sent) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic        cmd;
        logic [15:0] xc, yc;
        logic [16:0] yaw;
        logic [47:0] nx, ny;
        int          sh, hc;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: heading registers still at reset
        send_request(1'b0, 16'd0, 16'd0, 17'd0, 48'd0, 48'd0);           // no movement
        send_request(1'b0, 16'h7fff, 16'h8000, 17'd0, '1, '1);           // full counts, north
        send_request(1'b0, 16'h8000, 16'h7fff, 17'(36000), '0, '0);      // full turn wraps to 0
        send_request(1'b0, 16'd100, 16'(-200), 17'(-36000), '0, '0);
        send_request(1'b0, 16'd700, 16'd300, 17'(-5), '0, '0);           // rounds to -1, 3599
        send_request(1'b0, 16'd1000, 16'(-500), 17'd4, '0, '0);          // rounds down to 0
        send_request(1'b0, 16'd1000, 16'(-500), 17'd5, '0, '0);          // rounds up to 1
        send_request(1'b0, 16'(-3000), 16'd2500, 17'd4500, '0, '0);      // residual at +45 deg
        send_request(1'b0, 16'(-3000), 16'd2500, 17'd4510, '0, '0);      // residual flips negative
        send_request(1'b0, 16'd4000, 16'd4000, 17'd9000, '0, '0);        // exact quarter turns
        send_request(1'b0, 16'd4000, 16'd4000, 17'd27000, '0, '0);
        send_request(1'b0, 16'(-12345), 16'd23456, 17'd35990, '0, '0);
        send_request(1'b0, 16'd1234, 16'd4321, 17'h0ffff, '0, '0);       // yaw beyond a turn
        send_request(1'b0, 16'd1234, 16'd4321, 17'h10000, '0, '0);
        // position limits: set at the edge, then step over it both ways
        send_request(1'b1, '1, '1, '1, POS_MAX, POS_MIN);
        send_request(1'b0, 16'h7fff, 16'h8000, 17'd0, '0, '0);
        send_request(1'b0, 16'h8000, 16'h7fff, 17'd0, '0, '0);
        send_request(1'b1, '0, '0, '0, POS_MIN, POS_MAX);
        send_request(1'b0, 16'h8000, 16'h7fff, 17'd0, '1, '1);
        send_request(1'b1, 16'h5555, 16'haaaa, 17'h15555, 48'd0, 48'd0);  // back to origin

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                drain_results();
                case (ph)
                    1: begin sh = 3600;  hc = -3600; end
                    2: begin sh = -3600; hc = 3600;  end
                    3: begin sh = 4095;  hc = -4096; end   // outside the nominal range
                    4: begin sh = -4096; hc = 4095;  end
                    5: begin
                        sh = int'($urandom_range(0, 7200)) - 3600;
                        hc = int'($urandom_range(0, 7200)) - 3600;
                    end
                    6: begin
                        sh = int'($urandom_range(0, 8191)) - 4096;
                        hc = int'($urandom_range(0, 8191)) - 4096;
                    end
                    default: begin sh = 0; hc = 0; end
                endcase
                cfg_write(CFG_START_HEADING, sh);
                cfg_write(CFG_HEADING_CORR, hc);
            end
            // the last setting runs with both sides flat out
            if (ph == N_PHASES - 1)
                quiet <= 1'b1;
            for (int n = 0; n < REQS_PER_PHASE; n++) begin
                cmd = ($urandom_range(0, 9) == 0);
                xc  = 16'($urandom);
                yc  = 16'($urandom);
                // mostly modest motion, sometimes full-scale counts
                if ($urandom_range(0, 3) != 0) begin
                    xc = 16'(int'($urandom_range(0, 2000)) - 1000);
                    yc = 16'(int'($urandom_range(0, 2000)) - 1000);
                end
                if ($urandom_range(0, 4) == 0)
                    yaw = 17'($urandom);
                else
                    yaw = 17'(int'($urandom_range(0, 72000)) - 36000);
                nx = 48'({$urandom, $urandom});
                ny = 48'({$urandom, $urandom});
                // a third of the position sets land near a limit so later steps clip
                if (cmd && $urandom_range(0, 2) == 0) begin
                    nx = $urandom_range(0, 1) ? POS_MAX - 48'($urandom_range(0, 1 << 23))
                                              : POS_MIN + 48'($urandom_range(0, 1 << 23));
                    ny = $urandom_range(0, 1) ? POS_MAX - 48'($urandom_range(0, 1 << 23))
                                              : POS_MIN + 48'($urandom_range(0, 1 << 23));
                end
                send_request(cmd, xc, yc, yaw, nx, ny);
            end
        end

        drain_results();
        // room for a stray late result to show up
        repeat (60) @(posedge i_clk);

        $display("run covered %0d sensor samples and %0d position sets over %0d heading settings",
                 n_samples, n_sets, N_PHASES);
        $display("%0d results clipped at the position limits", clip_count);
        if (fail_count == 0 && pending == 0 && res_count == n_sent)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // hang guard, well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", n_sent - res_count);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
